[design/framed_packet_receiver_macros.svh]
// Assertion macros shared by the framed packet receiver.
`ifndef FRAMED_PACKET_RECEIVER_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FPR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/fpr_pkg.sv]
// Package with the shared types and constants of the framed packet receiver.
`default_nettype none

package fpr_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int POS_W  = 6;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_HEADER  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_HEADER = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_LIMIT  = 2'd2;

    localparam logic [BYTE_W-1:0] FIRST_HEADER_RST  = 8'h55;
    localparam logic [BYTE_W-1:0] SECOND_HEADER_RST = 8'hAA;
    localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RST  = 7'd64;

    // Write of one payload byte into the store; the entry index travels alongside.
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [BYTE_W-1:0] data;
    } store_wr_t;

    // One verified packet waiting to be replayed.
    typedef struct packed {
        logic             empty;
        logic             bank;
        logic [LEN_W-1:0] len;
    } pkt_cmd_t;

    // Back end hands a store bank back to the parser.
    typedef struct packed {
        logic en;
        logic bank;
    } bank_release_t;

endpackage

`default_nettype wire

[design/fpr_parser.sv]
// Front end: configuration registers, header/length/checksum parser and store writes.
`default_nettype none

module fpr_parser #(
    parameter int MAX_PAYLOAD = 64,
    parameter int IDX_W       = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fpr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fpr_pkg::BYTE_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [fpr_pkg::BYTE_W-1:0]       rx_byte,
    output fpr_pkg::store_wr_t               store_wr,
    output logic [IDX_W-1:0]                 store_idx,
    output logic                             push_valid,
    output fpr_pkg::pkt_cmd_t                push_cmd,
    input  logic                             queue_full,
    input  fpr_pkg::bank_release_t           release_bank,
    output logic [1:0]                       bank_busy
);
    import fpr_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_LEN,
        PH_DATA,
        PH_CSUM
    } phase_t;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  exp_len_reg, exp_len_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              wr_bank_reg, wr_bank_next;
    logic [1:0]        busy_reg, busy_next;
    logic [BYTE_W-1:0] first_header_reg;
    logic [BYTE_W-1:0] second_header_reg;
    logic [LEN_W-1:0]  length_limit_reg;

    logic              accept;
    logic [LEN_W-1:0]  eff_limit;
    logic [LEN_W-1:0]  count_inc;

    assign eff_limit = (length_limit_reg > MAX_LEN) ? MAX_LEN : length_limit_reg;
    assign count_inc = count_reg + LEN_W'(1);

    // Hold a data byte while its bank is busy, a checksum byte while the queue is full.
    assign in_stall = ((phase_reg == PH_DATA) && busy_reg[wr_bank_reg])
                   || ((phase_reg == PH_CSUM) && queue_full);
    assign accept   = in_valid && !in_stall;

    assign store_wr.en   = accept && (phase_reg == PH_DATA);
    assign store_wr.bank = wr_bank_reg;
    assign store_wr.data = rx_byte;
    assign store_idx     = count_reg[IDX_W-1:0];

    assign push_valid     = accept && (phase_reg == PH_CSUM) && (rx_byte == sum_reg);
    assign push_cmd.empty = (exp_len_reg == '0);
    assign push_cmd.bank  = wr_bank_reg;
    assign push_cmd.len   = exp_len_reg;

    assign bank_busy = busy_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        wr_bank_next = wr_bank_reg;
        busy_next    = busy_reg;

        if (release_bank.en)
        begin
            busy_next[release_bank.bank] = 1'b0;
        end

        if (accept)
        begin
            case (phase_reg)
                PH_HDR2:
                begin
                    if (rx_byte == second_header_reg)
                        phase_next = PH_LEN;
                    else if (rx_byte == first_header_reg)
                        phase_next = PH_HDR2;
                    else
                        phase_next = PH_HDR1;
                end
                PH_LEN:
                begin
                    if (rx_byte > {1'b0, eff_limit})
                    begin
                        phase_next = PH_HDR1;
                    end
                    else
                    begin
                        exp_len_next = rx_byte[LEN_W-1:0];
                        count_next   = '0;
                        sum_next     = '0;
                        phase_next   = (rx_byte == '0) ? PH_CSUM : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    sum_next   = sum_reg + rx_byte;
                    count_next = count_inc;
                    if (count_inc >= exp_len_reg)
                        phase_next = PH_CSUM;
                end
                PH_CSUM:
                begin
                    // A verified packet with payload locks its bank until replay ends.
                    if (push_valid && !push_cmd.empty)
                    begin
                        busy_next[wr_bank_reg] = 1'b1;
                        wr_bank_next           = !wr_bank_reg;
                    end
                    phase_next = PH_HDR1;
                end
                default:
                begin
                    phase_next = (rx_byte == first_header_reg) ? PH_HDR2 : PH_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HDR1;
            exp_len_reg       <= '0;
            count_reg         <= '0;
            sum_reg           <= '0;
            wr_bank_reg       <= 1'b0;
            busy_reg          <= '0;
            first_header_reg  <= FIRST_HEADER_RST;
            second_header_reg <= SECOND_HEADER_RST;
            length_limit_reg  <= LENGTH_LIMIT_RST;
        end
        else
        begin
            phase_reg   <= phase_next;
            exp_len_reg <= exp_len_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            wr_bank_reg <= wr_bank_next;
            busy_reg    <= busy_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIRST_HEADER:  first_header_reg  <= cfg_data;
                    CFG_SECOND_HEADER: second_header_reg <= cfg_data;
                    CFG_LENGTH_LIMIT:  length_limit_reg  <= cfg_data[LEN_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[design/fpr_cmd_fifo.sv]
// Two-entry queue of verified packets between the parser and the replay engine.
`default_nettype none

module fpr_cmd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fpr_pkg::pkt_cmd_t  push_cmd,
    input  logic               pop,
    output fpr_pkg::pkt_cmd_t  head,
    output logic               not_empty,
    output logic               full
);
    import fpr_pkg::*;

    localparam int DEPTH = 2;

    pkt_cmd_t   entry_reg [DEPTH];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign head      = entry_reg[rptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'(DEPTH));

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
            wptr_next = !wptr_reg;
        if (pop)
            rptr_next = !rptr_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

[design/fpr_replay.sv]
// Back end: two-bank payload store and the engine that replays verified packets.
`default_nettype none

module fpr_replay #(
    parameter int IDX_W       = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fpr_pkg::store_wr_t           store_wr,
    input  logic [IDX_W-1:0]             store_idx,
    input  logic                         cmd_valid,
    input  fpr_pkg::pkt_cmd_t            cmd,
    output logic                         cmd_pop,
    output fpr_pkg::bank_release_t       release_bank,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [fpr_pkg::BYTE_W-1:0]   payload_byte,
    output logic [fpr_pkg::POS_W-1:0]    byte_position,
    output logic [fpr_pkg::LEN_W-1:0]    packet_length,
    output logic                         last_of_packet
);
    import fpr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW
    } state_t;

    localparam int MEM_DEPTH = 1 << (IDX_W + 1);

    logic [BYTE_W-1:0] store_mem [MEM_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    state_t           state_reg;
    logic             bank_reg;
    logic             empty_reg;
    logic [LEN_W-1:0] len_reg;
    logic [IDX_W-1:0] k_reg;
    logic             is_last;
    logic             out_take;

    // Store entry MAX_PAYLOAD and above of each bank stays unused.
    always_ff @(posedge clk)
    begin
        if (store_wr.en)
            store_mem[{store_wr.bank, store_idx}] <= store_wr.data;
        if (state_reg == ST_READ)
            rd_data_reg <= store_mem[{bank_reg, k_reg}];
    end

    assign is_last  = empty_reg || ((LEN_W'(k_reg) + LEN_W'(1)) == len_reg);
    assign out_take = (state_reg == ST_SHOW) && !out_stall;

    assign cmd_pop           = (state_reg == ST_IDLE) && cmd_valid;
    assign release_bank.en   = out_take && is_last && !empty_reg;
    assign release_bank.bank = bank_reg;

    assign out_valid      = (state_reg == ST_SHOW);
    assign payload_byte   = empty_reg ? '0 : rd_data_reg;
    assign byte_position  = POS_W'(k_reg);
    assign packet_length  = len_reg;
    assign last_of_packet = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bank_reg  <= 1'b0;
            empty_reg <= 1'b0;
            len_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        bank_reg  <= cmd.bank;
                        empty_reg <= cmd.empty;
                        len_reg   <= cmd.len;
                        k_reg     <= '0;
                        state_reg <= cmd.empty ? ST_SHOW : ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_SHOW;
                end
                ST_SHOW:
                begin
                    if (!out_stall)
                    begin
                        if (is_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + IDX_W'(1);
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[design/framed_packet_receiver.sv]
// Top level of the framed packet receiver: parser, packet queue and replay engine.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+---------------------------------------
//   input    | in        | in_valid / in_stall | rx_byte
//   output   | out       | out_valid/out_stall | payload_byte, byte_position,
//            |           |                     | packet_length, last_of_packet
//   config   | in        | cfg_we              | cfg_index, cfg_data
//
// Received bytes are taken one per cycle. The parser stalls a payload byte while both
// store banks hold packets not yet replayed, and a checksum byte while the queue is full.
// Replay takes each packet off the queue, then reads each payload byte from the store
// and presents it, with the store read always before the presentation.
// Reset needs no clearing pass; the store is always written before it is read.
`default_nettype none

`include "framed_packet_receiver_macros.svh"

module framed_packet_receiver #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fpr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fpr_pkg::BYTE_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [fpr_pkg::BYTE_W-1:0]       rx_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [fpr_pkg::BYTE_W-1:0]       payload_byte,
    output logic [fpr_pkg::POS_W-1:0]        byte_position,
    output logic [fpr_pkg::LEN_W-1:0]        packet_length,
    output logic                             last_of_packet
);
    import fpr_pkg::*;

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    store_wr_t        store_wr;
    logic [IDX_W-1:0] store_idx;
    logic             push_valid;
    pkt_cmd_t         push_cmd;
    logic             queue_full;
    logic             queue_not_empty;
    pkt_cmd_t         queue_head;
    logic             cmd_pop;
    bank_release_t    release_bank;
    logic [1:0]       bank_busy;

    fpr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .IDX_W       (IDX_W)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .store_wr     (store_wr),
        .store_idx    (store_idx),
        .push_valid   (push_valid),
        .push_cmd     (push_cmd),
        .queue_full   (queue_full),
        .release_bank (release_bank),
        .bank_busy    (bank_busy)
    );

    fpr_cmd_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_cmd  (push_cmd),
        .pop       (cmd_pop),
        .head      (queue_head),
        .not_empty (queue_not_empty),
        .full      (queue_full)
    );

    fpr_replay #(
        .IDX_W       (IDX_W)
    ) u_replay (
        .clk            (clk),
        .rst_n          (rst_n),
        .store_wr       (store_wr),
        .store_idx      (store_idx),
        .cmd_valid      (queue_not_empty),
        .cmd            (queue_head),
        .cmd_pop        (cmd_pop),
        .release_bank   (release_bank),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_byte   (payload_byte),
        .byte_position  (byte_position),
        .packet_length  (packet_length),
        .last_of_packet (last_of_packet)
    );

    // The parser must never overwrite a bank that is still waiting for replay.
    `FPR_ASSERT_SAME(a_store_write_free_bank, clk, rst_n, store_wr.en,
        !bank_busy[store_wr.bank], "payload write into a bank pending replay")

    // A packet is only queued when the queue has room.
    `FPR_ASSERT_SAME(a_queue_no_overflow, clk, rst_n, push_valid, !queue_full,
        "packet queue overflow")

    // The last result of a packet sits at the final position of its payload.
    `FPR_ASSERT_SAME(a_last_position, clk, rst_n, out_valid && last_of_packet,
        (packet_length == '0) || (packet_length == (LEN_W'(byte_position) + LEN_W'(1))),
        "last mark at wrong payload position")

    // After a byte other than the last is taken, the next one needs a store read first.
    `FPR_ASSERT_NEXT(a_read_between_bytes, clk, rst_n,
        out_valid && !out_stall && !last_of_packet, !out_valid,
        "replay presented a byte without a store read")

endmodule

`default_nettype wire
